>>> rtl/bis_pkg.sv
// Shared constants, register indexes and controller/datapath link types
// for the bilinear image scaler. No dependencies.
package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 8;

  localparam int PIX_W    = 8;
  localparam int SIZE_W   = 9;
  localparam int DST_W    = 12;
  localparam int COL_W    = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W    = $clog2(MAX_SRC_HEIGHT);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int POS_W    = SIZE_W + FRAC_BITS;
  localparam int WT_W     = FRAC_BITS + 1;
  localparam int MIX_W    = PIX_W + FRAC_BITS + 1;
  localparam int ACC_W    = PIX_W + 2 * FRAC_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_CNT_W  = $clog2(POS_W);

  localparam logic [WT_W-1:0] UNITY = WT_W'(1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    NB_R0C0 = 2'd0,
    NB_R1C0 = 2'd1,
    NB_R0C1 = 2'd2,
    NB_R1C1 = 2'd3
  } nb_sel_t;

  typedef struct packed {
    logic    load;
    logic    div_go;
    logic    div_col;
    logic    ld_row_step;
    logic    ld_col_step;
    logic    rd_en;
    nb_sel_t rd_sel;
    logic    mix;
    logic    blend;
    logic    emit;
  } ctl_t;

  typedef struct packed {
    logic frame_start;
    logic div_done;
  } stat_t;

endpackage

>>> rtl/bis_div.sv
// Restoring divider, one quotient bit per cycle, for the scale steps.
// Depends on bis_pkg.
module bis_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [bis_pkg::POS_W-1:0]  dividend,
  input  logic [bis_pkg::DST_W-1:0]  divisor,
  output logic [bis_pkg::POS_W-1:0]  quotient,
  output logic                       done
);
  import bis_pkg::*;

  logic [DST_W-1:0]     rem;
  logic [POS_W-1:0]     quo;
  logic [DST_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic [DST_W:0]       trial;
  logic [DST_W:0]       diff;
  logic                 ge;

  assign trial = {rem, quo[POS_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(POS_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (run) begin
      // remainder stays below the divisor, so the low bits hold it
      rem <= ge ? diff[DST_W-1:0] : trial[DST_W-1:0];
      quo <= {quo[POS_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/bis_datapath.sv
// Datapath: configuration registers, frame store, position/counter state,
// neighbour fetch, two-stage weighting and result registers. Uses bis_pkg, bis_div.
module bis_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  bis_pkg::ctl_t                  ctl,
  output bis_pkg::stat_t                 stat,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bis_pkg::ROW_W-1:0]      src_row,
  input  logic [bis_pkg::COL_W-1:0]      src_col,
  input  logic [bis_pkg::PIX_W-1:0]      pixel_in,
  output logic                           done,
  output logic [bis_pkg::PIX_W-1:0]      pixel_out,
  output logic [bis_pkg::DST_W-1:0]      dst_row,
  output logic [bis_pkg::DST_W-1:0]      dst_col,
  output logic                           frame_last
);
  import bis_pkg::*;

  logic [SIZE_W-1:0] src_width, src_height;
  logic [DST_W-1:0]  dst_width, dst_height;
  logic [SIZE_W-1:0] sw, sh;
  logic [DST_W-1:0]  dw, dh;

  logic [POS_W-1:0]  row_position, col_position;
  logic              row_ovf, col_ovf;
  logic [POS_W-1:0]  row_step, col_step;
  logic [DST_W-1:0]  row_count, col_count;

  logic [PIX_W-1:0]  frame_store [2**ADDR_W];
  logic [PIX_W-1:0]  mem_q;
  logic              rd_val;
  nb_sel_t           rd_sel_q;
  logic [PIX_W-1:0]  nb [4];

  logic [MIX_W-1:0]  mix0, mix1;
  logic [ACC_W-1:0]  acc;

  logic [POS_W-1:0]  div_dividend;
  logic [DST_W-1:0]  div_divisor;
  logic [POS_W-1:0]  div_quotient;

  logic [SIZE_W-1:0] r_int, c_int, r0, c0, r0p1, c0p1, r1, c1;
  logic [SIZE_W-1:0] rd_r, rd_c;
  logic [WT_W-1:0]   wr1, wr0, wc1, wc0;
  logic [DST_W:0]    col_inc, row_inc;
  logic              last_col, last_row;
  logic [POS_W:0]    row_sum, col_sum;
  logic              wr_hit;

  // effective sizes: zero counts as one, source clamped to the store
  always_comb begin
    sw = (src_width == '0) ? SIZE_W'(1) :
         (src_width > SIZE_W'(MAX_SRC_WIDTH)) ? SIZE_W'(MAX_SRC_WIDTH) : src_width;
    sh = (src_height == '0) ? SIZE_W'(1) :
         (src_height > SIZE_W'(MAX_SRC_HEIGHT)) ? SIZE_W'(MAX_SRC_HEIGHT) : src_height;
    dw = (dst_width == '0) ? DST_W'(1) : dst_width;
    dh = (dst_height == '0) ? DST_W'(1) : dst_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_W'(256);
      src_height <= SIZE_W'(256);
      dst_width  <= DST_W'(256);
      dst_height <= DST_W'(256);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SIZE_W-1:0];
        REG_DST_WIDTH:  dst_width  <= cfg_data[DST_W-1:0];
        REG_DST_HEIGHT: dst_height <= cfg_data[DST_W-1:0];
        default: ;
      endcase
    end
  end

  // step divider, shared between rows and columns
  assign div_dividend = ctl.div_col ? {sw, FRAC_BITS'(0)} : {sh, FRAC_BITS'(0)};
  assign div_divisor  = ctl.div_col ? dw : dh;

  bis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (ctl.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (stat.div_done)
  );

  assign stat.frame_start = (row_count == '0) && (col_count == '0);

  // neighbour coordinates, integer part saturated to the last line/column
  always_comb begin
    r_int = row_position[POS_W-1:FRAC_BITS];
    c_int = col_position[POS_W-1:FRAC_BITS];
    r0    = (row_ovf || r_int > sh - 1'b1) ? sh - 1'b1 : r_int;
    c0    = (col_ovf || c_int > sw - 1'b1) ? sw - 1'b1 : c_int;
    r0p1  = r0 + 1'b1;
    c0p1  = c0 + 1'b1;
    r1    = (r0p1 < sh) ? r0p1 : r0;
    c1    = (c0p1 < sw) ? c0p1 : c0;
    case (ctl.rd_sel)
      NB_R0C0: begin rd_r = r0; rd_c = c0; end
      NB_R1C0: begin rd_r = r1; rd_c = c0; end
      NB_R0C1: begin rd_r = r0; rd_c = c1; end
      NB_R1C1: begin rd_r = r1; rd_c = c1; end
      default: begin rd_r = r0; rd_c = c0; end
    endcase
  end

  assign wr_hit = ctl.load && ({1'b0, src_row} < sh) && ({1'b0, src_col} < sw);

  always_ff @(posedge clk) begin
    if (wr_hit) frame_store[{src_row, src_col}] <= pixel_in;
    if (ctl.rd_en) mem_q <= frame_store[{rd_r[ROW_W-1:0], rd_c[COL_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_val <= 1'b0;
    end else begin
      rd_val <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) rd_sel_q <= ctl.rd_sel;
    if (rd_val) nb[rd_sel_q] <= mem_q;
  end

  // weights from the fractional parts
  assign wr1 = {1'b0, row_position[FRAC_BITS-1:0]};
  assign wr0 = UNITY - wr1;
  assign wc1 = {1'b0, col_position[FRAC_BITS-1:0]};
  assign wc0 = UNITY - wc1;

  always_ff @(posedge clk) begin
    if (ctl.mix) begin
      mix0 <= MIX_W'(nb[NB_R0C0]) * MIX_W'(wr0) + MIX_W'(nb[NB_R1C0]) * MIX_W'(wr1);
      mix1 <= MIX_W'(nb[NB_R0C1]) * MIX_W'(wr0) + MIX_W'(nb[NB_R1C1]) * MIX_W'(wr1);
    end
    if (ctl.blend) begin
      acc <= ACC_W'(mix0) * ACC_W'(wc0) + ACC_W'(mix1) * ACC_W'(wc1);
    end
  end

  assign col_inc  = {1'b0, col_count} + 1'b1;
  assign row_inc  = {1'b0, row_count} + 1'b1;
  assign last_col = col_inc >= {1'b0, dw};
  assign last_row = row_inc >= {1'b0, dh};
  assign row_sum  = {1'b0, row_position} + {1'b0, row_step};
  assign col_sum  = {1'b0, col_position} + {1'b0, col_step};

  // raster state; overflow flags stick so a runaway position stays saturated
  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      col_position <= '0;
      row_ovf      <= 1'b0;
      col_ovf      <= 1'b0;
      row_count    <= '0;
      col_count    <= '0;
      row_step     <= '0;
      col_step     <= '0;
    end else begin
      if (ctl.ld_row_step) row_step <= div_quotient;
      if (ctl.ld_col_step) begin
        col_step     <= div_quotient;
        row_position <= '0;
        col_position <= '0;
        row_ovf      <= 1'b0;
        col_ovf      <= 1'b0;
      end
      if (ctl.emit) begin
        if (last_col) begin
          col_count    <= '0;
          col_position <= '0;
          col_ovf      <= 1'b0;
          if (last_row) begin
            row_count    <= '0;
            row_position <= '0;
            row_ovf      <= 1'b0;
          end else begin
            row_count    <= row_inc[DST_W-1:0];
            row_position <= row_sum[POS_W-1:0];
            row_ovf      <= row_ovf | row_sum[POS_W];
          end
        end else begin
          col_count    <= col_inc[DST_W-1:0];
          col_position <= col_sum[POS_W-1:0];
          col_ovf      <= col_ovf | col_sum[POS_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pixel_out  <= acc[ACC_W-1 -: PIX_W];
      dst_row    <= row_count;
      dst_col    <= col_count;
      frame_last <= last_col && last_row;
    end
  end

endmodule

>>> rtl/bis_ctrl.sv
// Controller: sequences loads, step divisions at frame start, the four
// neighbour reads and the weighting stages. Uses bis_pkg.
module bis_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           cmd,
  input  bis_pkg::stat_t stat,
  output bis_pkg::ctl_t  ctl,
  output logic           busy
);
  import bis_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVR,
    ST_DIVR_W,
    ST_DIVC,
    ST_DIVC_W,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RDW,
    ST_MIX,
    ST_BLEND,
    ST_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.rd_sel = NB_R0C0;
    case (state)
      ST_IDLE: begin
        if (start && !cmd) ctl.load = 1'b1;
        if (start && cmd) state_next = stat.frame_start ? ST_DIVR : ST_RD0;
      end
      ST_DIVR: begin
        ctl.div_go = 1'b1;
        state_next = ST_DIVR_W;
      end
      ST_DIVR_W: begin
        ctl.ld_row_step = stat.div_done;
        if (stat.div_done) state_next = ST_DIVC;
      end
      ST_DIVC: begin
        ctl.div_go  = 1'b1;
        ctl.div_col = 1'b1;
        state_next  = ST_DIVC_W;
      end
      ST_DIVC_W: begin
        ctl.ld_col_step = stat.div_done;
        if (stat.div_done) state_next = ST_RD0;
      end
      ST_RD0: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = NB_R0C0;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = NB_R1C0;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = NB_R0C1;
        state_next = ST_RD3;
      end
      ST_RD3: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = NB_R1C1;
        state_next = ST_RDW;
      end
      // last read word lands in the neighbour registers
      ST_RDW: state_next = ST_MIX;
      ST_MIX: begin
        ctl.mix    = 1'b1;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        ctl.blend  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd) |=> busy)
    else $error("request transfer did not make the block busy");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> !busy)
    else $error("load held the block busy");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == ST_DIVR_W || state == ST_DIVC_W))
    else $error("divider finished outside a wait state");

  a_rd_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX) |-> $past(state == ST_RDW, 1) && $past(state == ST_RD3, 2))
    else $error("weighting started before all neighbours were read");

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE))
    else $error("busy out of step with the controller state");

endmodule

>>> rtl/bilinear_image_scaler_unit.sv
// Top level of the bilinear image scaler: controller plus datapath.
// Uses bis_pkg, bis_ctrl, bis_datapath.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     start / busy       cmd, src_row, src_col, pixel_in
//  result    done (strobe)      pixel_out, dst_row, dst_col, frame_last
//  config    cfg_we             cfg_index, cfg_data
//
// A load leaves busy low; the next transfer may follow at once.
// A request keeps busy high through four single-port frame store reads, a
// read-wait state, two weighting stages and the result register; done pulses
// in the cycle after, the first with busy low, so the next transfer may be
// accepted at the same edge that takes the result.
// The first request of a frame also runs two 17-step divisions for the row
// and column steps, on one shared divider.
// rst is synchronous; it restores the register defaults and restarts the frame.
// The frame store is not cleared. The result side cannot stall.
module bilinear_image_scaler_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [bis_pkg::ROW_W-1:0]      src_row,
  input  logic [bis_pkg::COL_W-1:0]      src_col,
  input  logic [bis_pkg::PIX_W-1:0]      pixel_in,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic [bis_pkg::PIX_W-1:0]      pixel_out,
  output logic [bis_pkg::DST_W-1:0]      dst_row,
  output logic [bis_pkg::DST_W-1:0]      dst_col,
  output logic                           frame_last
);
  import bis_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  bis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  bis_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_row    (src_row),
    .src_col    (src_col),
    .pixel_in   (pixel_in),
    .done       (done),
    .pixel_out  (pixel_out),
    .dst_row    (dst_row),
    .dst_col    (dst_col),
    .frame_last (frame_last)
  );

endmodule
